>>> design/ccf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared widths, action and status codes for the coalescing command FIFO.
// ----------------------------------------------------------------------------
package ccf_pkg;

	localparam int ACT_W        = 4;
	localparam int ID_W         = 4;
	localparam int PEND_W       = 11;
	localparam int QUEUE_DEPTH_DEF = 8;

	typedef logic [ACT_W-1:0]  act_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [PEND_W-1:0] pend_t;

	localparam act_t ACT_RECORD_START = 4'd2;
	localparam act_t ACT_RECORD_STOP  = 4'd3;
	localparam act_t ACT_SWITCH       = 4'd8;
	localparam act_t ACT_PAIR_ENTER   = 4'd9;
	localparam act_t ACT_PAIR_EXIT    = 4'd10;

	typedef enum logic {
		OP_POST = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_MERGED   = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_POPPED   = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// pending bit of an action, none for codes past the mask
	function automatic pend_t action_bit(input act_t a);
		pend_t b;
		b = '0;
		if (32'(a) < PEND_W) begin
			b = pend_t'(1) << a;
		end
		return b;
	endfunction

	function automatic logic is_coalescable(input act_t a);
		return (a == ACT_RECORD_START) || (a == ACT_RECORD_STOP) || (a == ACT_SWITCH)
			|| (a == ACT_PAIR_ENTER) || (a == ACT_PAIR_EXIT);
	endfunction

endpackage

>>> design/ccf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_if
// Valid/ready channels for commands into and results out of the FIFO.
// ----------------------------------------------------------------------------
interface ccf_cmd_if;
	logic             valid;
	logic             ready;
	ccf_pkg::opcode_t opcode;
	ccf_pkg::act_t    action_code;
	ccf_pkg::id_t     target_id;

	modport source (output valid, output opcode, output action_code, output target_id,
		input ready);
	modport sink (input valid, input opcode, input action_code, input target_id,
		output ready);
endinterface

interface ccf_rsp_if;
	logic             valid;
	logic             ready;
	ccf_pkg::status_t status;
	ccf_pkg::act_t    out_action;
	ccf_pkg::id_t     out_target;

	modport source (output valid, output status, output out_action, output out_target,
		input ready);
	modport sink (input valid, input status, input out_action, input out_target,
		output ready);
endinterface

>>> design/coalescing_command_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_command_fifo_top
// Command queue that merges repeated state-type actions while they are pending.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd (post an action or pop the oldest one) and
// every command yields exactly one result on rsp: enqueued, merged, dropped
// because the queue is full, popped (with action and target) or empty.
// Entries sit in a RAM with a registered read; pointers, fill
// count, pending bits and the latest switch target are flip-flops.
// A post or an empty pop has its result registered straight from the
// transfer; a pop of a queued entry first reads the RAM, then in S_READ
// builds the result and retires the entry.
// Posts are taken one per cycle while cmd.ready is high; a non-empty pop holds
// cmd.ready low during S_READ, the RAM read of the entry being popped.
// A two-slot result buffer sits on rsp, so a command is taken while one
// result still waits; with both slots full cmd.ready drops until rsp moves.
// Reset clears pointers, count, pending bits and the latest switch target
// (back to the default backend); RAM contents need no clearing.
// ----------------------------------------------------------------------------
module coalescing_command_fifo_top #(
	parameter int QUEUE_DEPTH = ccf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ccf_cmd_if.sink   cmd,
	ccf_rsp_if.source rsp
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = ccf_pkg::ACT_W + ccf_pkg::ID_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t              state_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [CNT_W-1:0]    count_q;
	ccf_pkg::pend_t      pend_q;
	ccf_pkg::id_t        latest_q;

	logic                out_vld_q;
	ccf_pkg::status_t    out_status_q;
	ccf_pkg::act_t       out_act_q;
	ccf_pkg::id_t        out_tgt_q;
	logic                skid_vld_q;
	ccf_pkg::status_t    skid_status_q;
	ccf_pkg::act_t       skid_act_q;
	ccf_pkg::id_t        skid_tgt_q;

	logic                xfer;
	logic                take;
	logic                post;
	logic                coal;
	logic                merged;
	ccf_pkg::pend_t      in_bit;
	logic                ram_we;
	logic                ram_re;
	logic [ENT_W-1:0]    ram_rdata;
	ccf_pkg::act_t       rd_act;
	ccf_pkg::id_t        rd_id;

	logic                res_vld;
	ccf_pkg::status_t    res_status;
	ccf_pkg::act_t       res_act;
	ccf_pkg::id_t        res_tgt;

	assign cmd.ready = (state_q == S_IDLE) && !skid_vld_q;
	assign xfer      = cmd.valid && cmd.ready;
	assign take      = out_vld_q && rsp.ready;

	assign post   = (cmd.opcode == ccf_pkg::OP_POST);
	assign coal   = ccf_pkg::is_coalescable(cmd.action_code);
	assign in_bit = ccf_pkg::action_bit(cmd.action_code);
	assign merged = coal && ((pend_q & in_bit) != '0);

	assign ram_we = xfer && post && !merged && (count_q != CNT_FULL);
	assign ram_re = xfer && !post && (count_q != '0);

	assign rd_act = ram_rdata[ENT_W-1:ccf_pkg::ID_W];
	assign rd_id  = ram_rdata[ccf_pkg::ID_W-1:0];

	ccf_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q),
		.wdata({cmd.action_code, cmd.target_id}),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// result of the command finishing in this cycle
	always_comb begin
		res_vld    = 1'b0;
		res_status = ccf_pkg::ST_EMPTY;
		res_act    = '0;
		res_tgt    = '0;
		if (state_q == S_READ) begin
			res_vld    = 1'b1;
			res_status = ccf_pkg::ST_POPPED;
			res_act    = rd_act;
			res_tgt    = (rd_act == ccf_pkg::ACT_SWITCH) ? latest_q : rd_id;
		end else if (xfer) begin
			if (post) begin
				res_vld = 1'b1;
				if (merged) begin
					res_status = ccf_pkg::ST_MERGED;
				end else if (count_q == CNT_FULL) begin
					res_status = ccf_pkg::ST_DROPPED;
				end else begin
					res_status = ccf_pkg::ST_ENQUEUED;
				end
			end else if (count_q == '0) begin
				res_vld    = 1'b1;
				res_status = ccf_pkg::ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			count_q       <= '0;
			pend_q        <= '0;
			latest_q      <= '0;
			out_vld_q     <= 1'b0;
			out_status_q  <= ccf_pkg::ST_EMPTY;
			out_act_q     <= '0;
			out_tgt_q     <= '0;
			skid_vld_q    <= 1'b0;
			skid_status_q <= ccf_pkg::ST_EMPTY;
			skid_act_q    <= '0;
			skid_tgt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (xfer) begin
						if (post) begin
							if (coal && (cmd.action_code == ccf_pkg::ACT_SWITCH)) begin
								latest_q <= cmd.target_id;
							end
							if (!merged) begin
								if (count_q == CNT_FULL) begin
									// dropped: its pending bit ends up clear
									pend_q <= pend_q & ~in_bit;
								end else begin
									if (coal) begin
										pend_q <= pend_q | in_bit;
									end
									wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
									count_q  <= count_q + 1'b1;
								end
							end
						end else if (count_q != '0) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					pend_q   <= pend_q & ~ccf_pkg::action_bit(rd_act);
					rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
					count_q  <= count_q - 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// output slot refills from the skid slot first, else from the new result
			if (!out_vld_q || take) begin
				if (skid_vld_q) begin
					out_status_q <= skid_status_q;
					out_act_q    <= skid_act_q;
					out_tgt_q    <= skid_tgt_q;
				end else begin
					out_vld_q <= res_vld;
					if (res_vld) begin
						out_status_q <= res_status;
						out_act_q    <= res_act;
						out_tgt_q    <= res_tgt;
					end
				end
			end
			// a new result never meets a full skid slot, see cmd.ready
			if (skid_vld_q) begin
				if (take) begin
					skid_vld_q <= 1'b0;
				end
			end else if (res_vld && out_vld_q && !take) begin
				skid_vld_q    <= 1'b1;
				skid_status_q <= res_status;
				skid_act_q    <= res_act;
				skid_tgt_q    <= res_tgt;
			end
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_status_q;
	assign rsp.out_action = out_act_q;
	assign rsp.out_target = out_tgt_q;

endmodule

>>> design/ccf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_ram
// Generic single-clock RAM, one write port, one read port with registered read.
// ----------------------------------------------------------------------------
module ccf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> tb/coalescing_command_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_command_fifo_top_tb
// Self-checking bench for the coalescing command FIFO. A directed table covers
// empty pops, merges, a full queue and the unlisted action codes. A random mix
// of posts and pops then runs against a behavioral copy of the queue. Both
// handshakes idle at random.
// ----------------------------------------------------------------------------
module coalescing_command_fifo_top_tb;
	import ccf_pkg::*;

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int RANDOM_CMDS = 1350;
	localparam int CYCLE_LIMIT = 400_000;

	// action codes with no entry in the coalescing list
	localparam act_t ACT_PLAIN_ZERO = 4'd0;
	localparam act_t ACT_PLAIN_ONE  = 4'd1;
	localparam act_t ACT_EXTRA_LO   = 4'd11;
	localparam act_t ACT_EXTRA_HI   = 4'd15;

	typedef struct packed {
		opcode_t op;
		act_t    act;
		id_t     tid;
	} cmd_t;

	typedef struct packed {
		status_t status;
		act_t    act;
		id_t     tgt;
	} rsp_t;

	typedef struct packed {
		cmd_t c;
		logic fixed;
		rsp_t want;
	} row_t;

	localparam rsp_t NO_RSP = '{ST_ENQUEUED, 4'd0, 4'd0};

	localparam row_t DIRECTED [26] = '{
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b1, '{ST_EMPTY,    4'd0, 4'd0}},
		'{'{OP_POST, ACT_RECORD_START, 4'd0},  1'b1, '{ST_ENQUEUED, 4'd0, 4'd0}},
		'{'{OP_POST, ACT_RECORD_START, 4'd15}, 1'b1, '{ST_MERGED,   4'd0, 4'd0}},
		'{'{OP_POST, ACT_SWITCH,       4'd5},  1'b0, NO_RSP},
		'{'{OP_POST, ACT_SWITCH,       4'd12}, 1'b0, NO_RSP},
		'{'{OP_POST, ACT_PLAIN_ZERO,   4'd15}, 1'b0, NO_RSP},
		'{'{OP_POST, ACT_EXTRA_HI,     4'd15}, 1'b0, NO_RSP},
		'{'{OP_POST, ACT_RECORD_STOP,  4'd10}, 1'b0, NO_RSP},
		'{'{OP_POST, ACT_PAIR_ENTER,   4'd1},  1'b0, NO_RSP},
		'{'{OP_POST, ACT_PAIR_EXIT,    4'd14}, 1'b0, NO_RSP},
		'{'{OP_POST, ACT_EXTRA_LO,     4'd7},  1'b0, NO_RSP},
		'{'{OP_POST, ACT_PLAIN_ONE,    4'd1},  1'b1, '{ST_DROPPED,  4'd0, 4'd0}},
		'{'{OP_POST, ACT_SWITCH,       4'd3},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b1, '{ST_POPPED, ACT_RECORD_START, 4'd0}},
		'{'{OP_POST, ACT_RECORD_START, 4'd9},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POST, ACT_SWITCH,       4'd6},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_EXTRA_HI,     4'd15}, 1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b0, NO_RSP},
		'{'{OP_POP,  ACT_PLAIN_ZERO,   4'd0},  1'b1, '{ST_EMPTY,    4'd0, 4'd0}}
	};

	logic clk;
	logic arst_n;

	ccf_cmd_if cmd ();
	ccf_rsp_if rsp ();

	coalescing_command_fifo_top #(
		.QUEUE_DEPTH(QDEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	// shadow of the queue contents and flags
	cmd_t  queued_q [$];
	pend_t pend_mask;
	id_t   switch_target;

	rsp_t rsp_due [$];
	int   fails;
	int   cycles;
	logic tx_calm;
	logic rx_calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic pend_t pend_bit(input act_t a);
		return (a < PEND_W) ? (pend_t'(1) << a) : '0;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	task automatic apply_command(input cmd_t c, output rsp_t r);
		pend_t b;
		logic  hit;
		cmd_t  head;
		r   = NO_RSP;
		b   = pend_bit(c.act);
		hit = 1'b0;
		if (c.op == OP_POST) begin
			if (c.act == ACT_RECORD_START || c.act == ACT_RECORD_STOP || c.act == ACT_SWITCH
				|| c.act == ACT_PAIR_ENTER || c.act == ACT_PAIR_EXIT) begin
				if (c.act == ACT_SWITCH) begin
					switch_target = c.tid;
				end
				hit       = |(pend_mask & b);
				pend_mask = pend_mask | b;
			end
			if (hit) begin
				r.status = ST_MERGED;
			end else if (queued_q.size() >= QDEPTH) begin
				pend_mask = pend_mask & ~b;
				r.status  = ST_DROPPED;
			end else begin
				queued_q.push_back(c);
				r.status = ST_ENQUEUED;
			end
		end else if (queued_q.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			head      = queued_q.pop_front();
			r.status  = ST_POPPED;
			r.act     = head.act;
			r.tgt     = (head.act == ACT_SWITCH) ? switch_target : head.tid;
			pend_mask = pend_mask & ~pend_bit(head.act);
		end
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send(input cmd_t c, input logic fixed, input rsp_t want);
		int   gap;
		rsp_t r;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.opcode      <= c.op;
		cmd.action_code <= c.act;
		cmd.target_id   <= c.tid;
		do @(posedge clk); while (!cmd.ready);
		apply_command(c, r);
		rsp_due.push_back(fixed ? want : r);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[coalescing_command_fifo_top] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_due.size() == 0) begin
				$display("%0t: result with none pending: status %0d action %0d target %0d",
					$time, rsp.status, rsp.out_action, rsp.out_target);
				fails++;
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
					fails++;
				end
				if (rsp.out_action !== want.act) begin
					$display("%0t: out_action expected %0d got %0d", $time, want.act,
						rsp.out_action);
					fails++;
				end
				if (rsp.out_target !== want.tgt) begin
					$display("%0t: out_target expected %0d got %0d", $time, want.tgt,
						rsp.out_target);
					fails++;
				end
			end
		end
	end

	// result side back-pressure, with randomly chosen calm stretches in which ready stays high
	initial begin
		int hold;
		int n;
		hold      = 0;
		n         = 0;
		rx_calm   = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n++;
			if (n % 256 == 0) begin
				rx_calm = ($urandom_range(3) == 0);
			end
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				hold--;
			end else begin
				rsp.ready <= 1'b1;
				if (!rx_calm) begin
					hold = pick_gap();
				end
			end
		end
	end

	initial begin
		int   i;
		int   post_pct;
		int   r;
		cmd_t c;
		post_pct        = 50;
		fails           = 0;
		cycles          = 0;
		tx_calm         = 1'b0;
		pend_mask       = '0;
		switch_target   = '0;
		arst_n          = 1'b0;
		cmd.valid       = 1'b0;
		cmd.opcode      = OP_POST;
		cmd.action_code = '0;
		cmd.target_id   = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[k]) begin
			send(DIRECTED[k].c, DIRECTED[k].fixed, DIRECTED[k].want);
		end

		for (i = 0; i < RANDOM_CMDS; i++) begin
			// each block of 60 commands leans toward filling, draining or neither
			if (i % 60 == 0) begin
				case ($urandom_range(2))
					0: post_pct = 35;
					1: post_pct = 55;
					default: post_pct = 80;
				endcase
				tx_calm = ($urandom_range(4) == 0);
			end
			c.op  = ($urandom_range(99) < post_pct) ? OP_POST : OP_POP;
			c.tid = id_t'($urandom_range(15));
			r     = $urandom_range(99);
			if (r < 65) begin
				case ($urandom_range(4))
					0: c.act = ACT_RECORD_START;
					1: c.act = ACT_RECORD_STOP;
					2: c.act = ACT_SWITCH;
					3: c.act = ACT_PAIR_ENTER;
					default: c.act = ACT_PAIR_EXIT;
				endcase
			end else if (r < 93) begin
				c.act = act_t'($urandom_range(ACT_PAIR_EXIT));
			end else begin
				c.act = act_t'($urandom_range(ACT_EXTRA_HI, ACT_EXTRA_LO));
			end
			send(c, 1'b0, NO_RSP);
		end
		cmd.valid <= 1'b0;

		while (rsp_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0) begin
			$display("[coalescing_command_fifo_top] OK");
		end else begin
			$display("[coalescing_command_fifo_top] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
design/ccf_pkg.sv
design/ccf_if.sv
design/ccf_ram.sv
design/coalescing_command_fifo_top.sv
tb/coalescing_command_fifo_top_tb.sv
